FILE: hw/rtl/tsb_pkg.sv
package tsb_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] REG_PRESENT = 3'd0;
  localparam logic [2:0] REG_WIDTH   = 3'd1;
  localparam logic [2:0] REG_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_BPP     = 3'd3;
  localparam logic [2:0] REG_FILTER  = 3'd4;

  localparam int DivSteps = 17;

  typedef struct packed {
    logic        operation;
    logic [7:0]  texel_x;
    logic [7:0]  texel_y;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [23:0] coord_u;
    logic [23:0] coord_v;
  } tsb_in_t;

  typedef struct packed {
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] blue;
  } tsb_out_t;

  typedef struct packed {
    logic       present;
    logic       filter;
    logic [8:0] w;
    logic [8:0] h;
    logic [2:0] bpp;
  } tsb_cfg_t;

  typedef struct packed {
    logic        op;
    logic        black;
    logic        bilinear;
    logic [8:0]  x0;
    logic [8:0]  y0;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [23:0] data;
  } tsb_entry_t;

endpackage

FILE: hw/rtl/texture_sampler_bilinear.sv
// channel   direction  payload      handshake
// in        input      tsb_in_t     in_valid_i / in_stall_o
// out       output     tsb_out_t    out_valid_o / out_stall_i
// apb       input      registers    psel, penable, pwrite, pready
// the input takes no new word until the front has pushed the last one; a sample word
// passes the multiply and the 17-step remainder unit in the front, a sample without texture skips them
// a sample result is registered at the output after the back has read and weighted its texels,
// which takes four reads of the single texel ram port; a sample without texture skips the reads
// rst_ni clears control state only; the texel ram is not cleared
// out_stall_i holds the back end; a two-entry queue lets the front keep working
module texture_sampler_bilinear import tsb_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tsb_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output tsb_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       present_q, filter_q;
  logic [8:0] width_q, height_q;
  logic [2:0] bpp_q;
  logic [2:0] reg_idx;
  logic       cfg_we;
  tsb_cfg_t   cfg;
  logic       push, full, pop, fifo_valid;
  tsb_entry_t push_entry, head_entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_PRESENT: prdata = {31'd0, present_q};
      REG_WIDTH:   prdata = {23'd0, width_q};
      REG_HEIGHT:  prdata = {23'd0, height_q};
      REG_BPP:     prdata = {29'd0, bpp_q};
      REG_FILTER:  prdata = {31'd0, filter_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.present = present_q;
    cfg.filter  = filter_q;
    cfg.bpp     = bpp_q;
    if (width_q == 9'd0) begin
      cfg.w = 9'd1;
    end else if (32'(width_q) > MAX_WIDTH) begin
      cfg.w = 9'(MAX_WIDTH);
    end else begin
      cfg.w = width_q;
    end
    if (height_q == 9'd0) begin
      cfg.h = 9'd1;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      cfg.h = 9'(MAX_HEIGHT);
    end else begin
      cfg.h = height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      width_q   <= 9'd1;
      height_q  <= 9'd1;
      bpp_q     <= 3'd3;
      filter_q  <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_PRESENT: present_q <= pwdata[0];
        REG_WIDTH:   width_q   <= pwdata[8:0];
        REG_HEIGHT:  height_q  <= pwdata[8:0];
        REG_BPP:     bpp_q     <= pwdata[2:0];
        REG_FILTER:  filter_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  tsb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  tsb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (head_entry)
  );

  tsb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (fifo_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue overflow");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fifo_valid) else $error("queue underflow");

  a_black_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !present_q |-> out_data_o == '0)
    else $error("sample without texture not black");
`endif

endmodule

FILE: hw/rtl/tsb_ram.sv
module tsb_ram import tsb_pkg::*; #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/tsb_fifo.sv
module tsb_fifo import tsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tsb_entry_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output tsb_entry_t data_o
);

  tsb_entry_t mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/tsb_front.sv
module tsb_front import tsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tsb_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  tsb_in_t    in_data_i,
  output logic       push_o,
  output tsb_entry_t entry_o,
  input  logic       full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]  state_q, state_d;
  tsb_in_t     item_q;
  logic [4:0]  cnt_q;
  logic [16:0] du_q, dv_q;
  logic [8:0]  ru_q, rv_q;
  logic [15:0] fx_q, fy_q;
  logic [23:0] mu, mv;
  logic [32:0] pu, pv;
  logic [9:0]  tu, tv;
  logic        accept;

  assign in_stall_o = state_q != F_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (state_q == F_PUSH) && !full_i;

  always_comb begin
    mu = item_q.coord_u[23] ? (~item_q.coord_u + 24'd1) : item_q.coord_u;
    mv = item_q.coord_v[23] ? (~item_q.coord_v + 24'd1) : item_q.coord_v;
    pu = {9'd0, mu} * {24'd0, cfg_i.w};
    pv = {9'd0, mv} * {24'd0, cfg_i.h};
    tu = {ru_q, du_q[16]};
    tv = {rv_q, dv_q[16]};
    if (tu >= {1'b0, cfg_i.w}) begin
      tu = tu - {1'b0, cfg_i.w};
    end
    if (tv >= {1'b0, cfg_i.h}) begin
      tv = tv - {1'b0, cfg_i.h};
    end
  end

  always_comb begin
    entry_o.op       = item_q.operation;
    entry_o.black    = !cfg_i.present;
    entry_o.bilinear = cfg_i.filter;
    entry_o.fx       = fx_q;
    entry_o.fy       = fy_q;
    entry_o.data     = {item_q.byte_two, item_q.byte_one, item_q.byte_zero};
    if (item_q.operation == OP_WRITE) begin
      entry_o.x0 = {1'b0, item_q.texel_x};
      entry_o.y0 = {1'b0, item_q.texel_y};
    end else begin
      entry_o.x0 = ru_q;
      entry_o.y0 = rv_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (in_data_i.operation == OP_WRITE || !cfg_i.present) begin
            state_d = F_PUSH;
          end else begin
            state_d = F_MUL;
          end
        end
      end
      F_MUL:  state_d = F_DIV;
      F_DIV: begin
        if (cnt_q == 5'(DivSteps - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    case (state_q)
      F_MUL: begin
        du_q  <= (!cfg_i.filter && item_q.coord_u[23]) ? 17'd0 : pu[32:16];
        dv_q  <= (!cfg_i.filter && item_q.coord_v[23]) ? 17'd0 : pv[32:16];
        fx_q  <= cfg_i.filter ? pu[15:0] : 16'd0;
        fy_q  <= cfg_i.filter ? pv[15:0] : 16'd0;
        ru_q  <= 9'd0;
        rv_q  <= 9'd0;
        cnt_q <= 5'd0;
      end
      F_DIV: begin
        ru_q  <= tu[8:0];
        rv_q  <= tv[8:0];
        du_q  <= {du_q[15:0], 1'b0};
        dv_q  <= {dv_q[15:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/tsb_back.sv
module tsb_back import tsb_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tsb_cfg_t   cfg_i,
  input  logic       valid_i,
  input  tsb_entry_t entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output tsb_out_t   out_data_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]    state_q, state_d;
  tsb_entry_t    ent_q;
  logic [2:0]    cnt_q;
  logic [33:0]   wt_q, wt;
  logic          acc_v_q;
  logic [40:0]   sum_r_q, sum_g_q, sum_b_q;
  logic [40:0]   rnd_r, rnd_g, rnd_b;
  logic          out_valid_q;
  tsb_out_t      out_data_q;
  logic [1:0]    corner;
  logic          issue, free, we, in_range;
  logic [9:0]    x1n, y1n;
  logic [8:0]    x1, y1, rx, ry;
  logic [16:0]   ex, ey;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   rdata;
  logic [7:0]    ch_r, ch_g, ch_b;

  assign corner      = cnt_q[1:0];
  assign issue       = (state_q == B_RUN) && !cnt_q[2];
  assign free        = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == B_IDLE) && valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign in_range = (32'(entry_i.x0) < MAX_WIDTH) && (32'(entry_i.y0) < MAX_HEIGHT);
  assign we       = pop_o && (entry_i.op == OP_WRITE) && in_range;
  assign waddr    = AW'(32'(entry_i.y0) * MAX_WIDTH + 32'(entry_i.x0));

  always_comb begin
    x1n   = {1'b0, ent_q.x0} + 10'd1;
    y1n   = {1'b0, ent_q.y0} + 10'd1;
    x1    = (x1n == {1'b0, cfg_i.w}) ? 9'd0 : x1n[8:0];
    y1    = (y1n == {1'b0, cfg_i.h}) ? 9'd0 : y1n[8:0];
    rx    = corner[0] ? x1 : ent_q.x0;
    ry    = corner[1] ? y1 : ent_q.y0;
    raddr = AW'(32'(ry) * MAX_WIDTH + 32'(rx));
    ex    = corner[0] ? {1'b0, ent_q.fx} : (17'h10000 - {1'b0, ent_q.fx});
    ey    = corner[1] ? {1'b0, ent_q.fy} : (17'h10000 - {1'b0, ent_q.fy});
    wt    = {17'd0, ex} * {17'd0, ey};
  end

  always_comb begin
    if (cfg_i.bpp > 3'd2) begin
      ch_r = rdata[23:16];
      ch_g = rdata[15:8];
      ch_b = rdata[7:0];
    end else if (cfg_i.bpp == 3'd1) begin
      ch_r = rdata[7:0];
      ch_g = rdata[7:0];
      ch_b = rdata[7:0];
    end else begin
      ch_r = 8'd0;
      ch_g = 8'd0;
      ch_b = 8'd0;
    end
    rnd_r = sum_r_q + 41'h8000;
    rnd_g = sum_g_q + 41'h8000;
    rnd_b = sum_b_q + 41'h8000;
  end

  tsb_ram #(
    .WIDTH (24),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (entry_i.data),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_o && entry_i.op == OP_SAMPLE) begin
          state_d = entry_i.black ? B_DONE : B_RUN;
        end
      end
      B_RUN: begin
        if (cnt_q[2]) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q   <= entry_i;
      cnt_q   <= 3'd0;
      sum_r_q <= 41'd0;
      sum_g_q <= 41'd0;
      sum_b_q <= 41'd0;
    end else begin
      if (issue) begin
        cnt_q <= cnt_q + 3'd1;
        wt_q  <= wt;
      end
      if (acc_v_q) begin
        sum_r_q <= sum_r_q + {33'd0, ch_r} * {7'd0, wt_q};
        sum_g_q <= sum_g_q + {33'd0, ch_g} * {7'd0, wt_q};
        sum_b_q <= sum_b_q + {33'd0, ch_b} * {7'd0, wt_q};
      end
    end
    if (state_q == B_DONE && free) begin
      out_data_q <= '{red: rnd_r[39:16], green: rnd_g[39:16], blue: rnd_b[39:16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      acc_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_v_q <= issue && (ent_q.bilinear || corner == 2'd0);
      if (state_q == B_DONE && free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/texture_sampler_bilinear_checker.sv
`timescale 1ns / 1ps

module texture_sampler_bilinear_checker import tsb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_o,
  input  tsb_in_t  in_data_i,
  input  logic     out_valid_o,
  input  logic     out_stall_i,
  input  tsb_out_t out_data_o,
  input  logic     psel,
  input  logic     penable,
  input  logic     pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic     pready,
  output int       fail_count,
  output int       pending,
  output int       samples_seen
);

  logic [23:0] texels [0:65535];
  logic        present;
  logic [8:0]  tw;
  logic [8:0]  th;
  logic [2:0]  bpp;
  logic        filt;
  tsb_out_t    colors_q[$];

  function automatic int unsigned fit_size(logic [8:0] r);
    if (r == 0) return 1;
    if (r > 256) return 256;
    return 32'(r);
  endfunction

  function automatic void texel_rgb(int unsigned x, int unsigned y,
                                    output int unsigned ch[3]);
    logic [23:0] t;
    t = texels[16'(y * 256 + x)];
    if (bpp > 2) begin
      ch[0] = 32'(t[23:16]); ch[1] = 32'(t[15:8]); ch[2] = 32'(t[7:0]);
    end else if (bpp == 1) begin
      ch[0] = 32'(t[7:0]); ch[1] = 32'(t[7:0]); ch[2] = 32'(t[7:0]);
    end else begin
      ch[0] = 0; ch[1] = 0; ch[2] = 0;
    end
  endfunction

  function automatic longint unsigned magnitude(logic [23:0] c);
    if (c[23]) return 64'h1000000 - 64'(c);
    return 64'(c);
  endfunction

  function automatic tsb_out_t sample_color(tsb_in_t d);
    tsb_out_t o;
    int unsigned w, h, ch[3], x0, y0, x1, y1, px[4], py[4];
    longint unsigned au, av, fx, fy, wt[4], sum[3];
    w = fit_size(tw);
    h = fit_size(th);
    o = '0;
    if (!present) return o;
    if (!filt) begin
      x0 = d.coord_u[23] ? 0 : 32'(((magnitude(d.coord_u) * w) >> 16) % w);
      y0 = d.coord_v[23] ? 0 : 32'(((magnitude(d.coord_v) * h) >> 16) % h);
      texel_rgb(x0, y0, ch);
      o.red = 24'(ch[0] << 16); o.green = 24'(ch[1] << 16); o.blue = 24'(ch[2] << 16);
      return o;
    end
    au = magnitude(d.coord_u) * w;
    av = magnitude(d.coord_v) * h;
    x0 = 32'((au >> 16) % w); y0 = 32'((av >> 16) % h);
    x1 = (x0 + 1) % w;   y1 = (y0 + 1) % h;
    fx = au & 64'hFFFF;  fy = av & 64'hFFFF;
    wt[0] = (65536 - fx) * (65536 - fy);
    wt[1] = fx * (65536 - fy);
    wt[2] = (65536 - fx) * fy;
    wt[3] = fx * fy;
    px = '{x0, x1, x0, x1};
    py = '{y0, y0, y1, y1};
    sum = '{0, 0, 0};
    for (int c = 0; c < 4; c++) begin
      texel_rgb(px[c], py[c], ch);
      for (int k = 0; k < 3; k++) sum[k] += longint'(ch[k]) * wt[c];
    end
    o.red   = 24'((sum[0] + 32768) >> 16);
    o.green = 24'((sum[1] + 32768) >> 16);
    o.blue  = 24'((sum[2] + 32768) >> 16);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = colors_q.size();

  initial begin
    fail_count = 0;
    samples_seen = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present <= 1'b0; tw <= 9'd1; th <= 9'd1; bpp <= 3'd3; filt <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_PRESENT: present <= pwdata[0];
          REG_WIDTH:   tw <= pwdata[8:0];
          REG_HEIGHT:  th <= pwdata[8:0];
          REG_BPP:     bpp <= pwdata[2:0];
          REG_FILTER:  filt <= pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.operation == OP_WRITE)
          texels[{in_data_i.texel_y, in_data_i.texel_x}] <=
            {in_data_i.byte_two, in_data_i.byte_one, in_data_i.byte_zero};
        else
          colors_q.push_back(sample_color(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        samples_seen++;
        if (colors_q.size() == 0) begin
          report_mismatch("unexpected word", out_data_o.red, 24'd0);
        end else begin
          tsb_out_t e;
          e = colors_q.pop_front();
          if (out_data_o.red !== e.red) report_mismatch("red", out_data_o.red, e.red);
          if (out_data_o.green !== e.green)
            report_mismatch("green", out_data_o.green, e.green);
          if (out_data_o.blue !== e.blue) report_mismatch("blue", out_data_o.blue, e.blue);
        end
      end
    end
  end

endmodule

FILE: tb/texture_sampler_bilinear_test.sv
`timescale 1ns / 1ps

module texture_sampler_bilinear_test import tsb_pkg::*;;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tsb_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tsb_out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending, samples_seen;
  int cycles = 0;
  int sent = 0;
  bit hold_long = 0;
  bit quiet = 0;
  int unsigned cw, ch_;

  texture_sampler_bilinear u_top (.*);

  texture_sampler_bilinear_checker u_chk (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver side stall bursts and one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_long = 0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_word(tsb_in_t d);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic put_texel(int x, int y, logic [23:0] v);
    tsb_in_t d;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    d = rnd[$bits(tsb_in_t)-1:0];
    d.operation = OP_WRITE;
    d.texel_x = 8'(x); d.texel_y = 8'(y);
    {d.byte_two, d.byte_one, d.byte_zero} = v;
    send_word(d);
  endtask

  function automatic logic [23:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic sample(logic [23:0] u, logic [23:0] v);
    tsb_in_t d;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    d = rnd[$bits(tsb_in_t)-1:0];
    d.operation = OP_SAMPLE;
    d.coord_u = u; d.coord_v = v;
    send_word(d);
  endtask

  // fill the whole used area so no unwritten texel is ever read
  task automatic fill_area(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        put_texel(x, y, 24'($urandom));
  endtask

  task automatic configure(int w, int h, int bpp, int filt, int pres);
    drain();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_BPP, bpp);
    reg_write(REG_FILTER, filt);
    reg_write(REG_PRESENT, pres);
  endtask

  initial begin
    int w, h;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: reset sizes with no texture first, then small fixed sizes and settings
    put_texel(0, 0, 24'hFFFFFF);
    sample(24'h7FFFFF, 24'h800000);
    configure(1, 1, 3, 0, 1);
    sample(24'h000000, 24'hFFFFFF);
    put_texel(0, 0, 24'h000000);
    sample(24'h7FFFFF, 24'h7FFFFF);
    configure(2, 2, 1, 1, 1);
    put_texel(0, 0, 24'hFFFFFF); put_texel(1, 0, 24'h00FF80);
    put_texel(0, 1, 24'h123456); put_texel(1, 1, 24'hABCDEF);
    sample(24'h008000, 24'h008000);
    sample(24'h800000, 24'h7FFFFF);
    configure(2, 2, 2, 1, 1);
    sample(24'h00C000, 24'h004000);
    configure(0, 0, 0, 0, 1);
    sample(24'h123456, 24'h654321);
    configure(2, 2, 7, 0, 1);
    sample(24'h00FFFF, 24'hFF0000);
    sample(24'hFFFFFF, 24'h00FFFF);
    // random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin w = 256; h = 256; end
        1: begin w = 511; h = 300; end
        default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); end
      endcase
      if (ph == 11) quiet = 1;
      configure(w, h, $urandom_range(0, 7), $urandom_range(0, 1), int'(ph != 3));
      cw = (w > 256) ? 256 : (w == 0 ? 1 : w);
      ch_ = (h > 256) ? 256 : (h == 0 ? 1 : h);
      if (cw * ch_ <= 64) fill_area(cw, ch_);
      else begin
        // big sizes: touch only the corners so samples stay inside written texels
        for (int y = 0; y < 256; y += 255)
          for (int x = 0; x < 256; x += 255) put_texel(x, y, 24'($urandom));
      end
      if (ph == 4) hold_long = 1;
      for (int i = 0; i < 45; i++) begin
        if (cw * ch_ > 64) begin
          // coordinates 0 and ~-0 map to corner texels only in nearest mode
          configure(w, h, $urandom_range(0, 7), 0, 1);
          sample(24'h800000 | 24'($urandom), 24'h000000);
          break;
        end
        if ($urandom_range(0, 3) == 0)
          put_texel($urandom_range(0, cw - 1), $urandom_range(0, ch_ - 1),
                    24'($urandom));
        else
          sample(pick_coord(), pick_coord());
      end
    end
    drain();
    $display("sent %0d input words, checked %0d output words", sent, samples_seen);
    $display("covered nearest and bilinear modes, all byte counts, size extremes");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
